// ----- rtl/smcm_pkg.sv -----
package smcm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int VALUE_W  = 14;
  localparam int PROD_W   = SAMPLE_W + VALUE_W;
  localparam int PART_SHIFT = 7;
  localparam int CFG_W    = 16;
  localparam int DIV_CELLS = VALUE_W;

  localparam logic [7:0] STATUS_PITCH = 8'hE0;
  localparam logic [7:0] STATUS_CC    = 8'hB0;
  localparam logic [7:0] CHANNEL_BIAS = 8'hFF;

  typedef enum logic [2:0] {
    REG_IN_MIN,
    REG_IN_MAX,
    REG_OUT_MIN,
    REG_OUT_MAX,
    REG_CHANNEL,
    REG_MESSAGE_KIND,
    REG_CC_NUMBER,
    REG_CC_LSB_NUMBER
  } cfg_index_t;

  typedef enum logic {
    KIND_PITCH,
    KIND_CC
  } kind_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_min;
    logic signed [SAMPLE_W-1:0] in_max;
    logic [VALUE_W-1:0]         out_min;
    logic [VALUE_W-1:0]         out_max;
    logic [4:0]                 channel;
    kind_t                      message_kind;
    logic [6:0]                 cc_number;
    logic [6:0]                 cc_lsb_number;
  } cfg_t;

  // partial remainder, dividend bits still to shift in, quotient so far
  typedef struct packed {
    logic [SAMPLE_W-1:0] rem;
    logic [VALUE_W-1:0]  dvd;
    logic [VALUE_W-1:0]  q;
  } div_t;

  function automatic logic range_neg(input cfg_t c);
    return c.out_max < c.out_min;
  endfunction

  function automatic logic [VALUE_W-1:0] range_mag(input cfg_t c);
    return range_neg(c) ? c.out_min - c.out_max : c.out_max - c.out_min;
  endfunction

endpackage

// ----- rtl/smcm_front.sv -----
module smcm_front import smcm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                out_valid,
  input  logic                out_ready,
  output div_t                out_data
);

  logic                       valid0;
  logic [SAMPLE_W-1:0]        offset;
  logic                       valid1;
  logic [PROD_W-1:0]          prod;
  logic                       ready1;
  logic                       in_window;
  logic signed [SAMPLE_W:0]   diff;

  assign in_window = ($signed(sample) >= cfg.in_min) && ($signed(sample) <= cfg.in_max);
  assign diff      = $signed({sample[SAMPLE_W-1], sample})
                   - $signed({cfg.in_min[SAMPLE_W-1], cfg.in_min});

  assign ready1   = !valid1 || out_ready;
  assign in_ready = !valid0 || ready1;

  // out-of-window samples are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else if (in_ready) begin
      valid0 <= in_valid && in_window;
    end
    if (in_ready) begin
      offset <= diff[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (ready1) begin
      valid1 <= valid0;
    end
    if (ready1) begin
      prod <= PROD_W'(range_mag(cfg)) * PROD_W'(offset);
    end
  end

  assign out_valid    = valid1;
  assign out_data.rem = prod[PROD_W-1:VALUE_W];
  assign out_data.dvd = prod[VALUE_W-1:0];
  assign out_data.q   = '0;

endmodule

// ----- rtl/smcm_div_cell.sv -----
module smcm_div_cell import smcm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [SAMPLE_W-1:0] divisor,
  input  logic                in_valid,
  output logic                in_ready,
  input  div_t                in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output div_t                out_data
);

  logic                valid;
  div_t                data;
  div_t                data_next;
  logic [SAMPLE_W:0]   trial;
  logic [SAMPLE_W:0]   diff;
  logic                fits;

  assign trial = {in_data.rem, in_data.dvd[VALUE_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    data_next.rem = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
    data_next.dvd = {in_data.dvd[VALUE_W-2:0], 1'b0};
    data_next.q   = {in_data.q[VALUE_W-2:0], fits};
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ----- rtl/smcm_out.sv -----
module smcm_out import smcm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] quotient,
  output logic               m_valid,
  input  logic               m_ready,
  output logic [23:0]        m_data,
  output logic               m_last
);

  logic               busy;
  logic               phase;
  logic [VALUE_W-1:0] val;
  logic [VALUE_W-1:0] val_next;
  logic [VALUE_W-1:0] step;
  logic [VALUE_W-1:0] mag;
  logic               in_zero;
  logic               last;
  logic [7:0]         status_byte;
  logic [7:0]         data_one;
  logic [7:0]         data_two;

  assign mag     = range_mag(cfg);
  assign in_zero = cfg.in_max == cfg.in_min;

  always_comb begin
    if (mag == '0) begin
      step = '0;
    end else if (in_zero) begin
      step = mag >> 1;
    end else begin
      step = quotient;
    end
    val_next = range_neg(cfg) ? cfg.out_min - step : cfg.out_min + step;
  end

  assign last = (cfg.message_kind == KIND_PITCH) || (cfg.cc_lsb_number == '0) || phase;
  assign in_ready = !busy || (m_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy  <= 1'b1;
      phase <= 1'b0;
    end else if (busy && m_ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
    if (in_valid && in_ready) begin
      val <= val_next;
    end
  end

  always_comb begin
    if (cfg.message_kind == KIND_PITCH) begin
      status_byte = STATUS_PITCH + {3'b000, cfg.channel} + CHANNEL_BIAS;
      data_one    = {1'b0, val[PART_SHIFT-1:0]};
      data_two    = {1'b0, val[VALUE_W-1:PART_SHIFT]};
    end else if (cfg.cc_lsb_number == '0) begin
      status_byte = STATUS_CC + {3'b000, cfg.channel} + CHANNEL_BIAS;
      data_one    = {1'b0, cfg.cc_number};
      data_two    = val[7:0];
    end else if (!phase) begin
      status_byte = STATUS_CC + {3'b000, cfg.channel} + CHANNEL_BIAS;
      data_one    = {1'b0, cfg.cc_number};
      data_two    = {1'b0, val[VALUE_W-1:PART_SHIFT]};
    end else begin
      status_byte = STATUS_CC + {3'b000, cfg.channel} + CHANNEL_BIAS;
      data_one    = {1'b0, cfg.cc_lsb_number};
      data_two    = {1'b0, val[PART_SHIFT-1:0]};
    end
  end

  assign m_valid = busy;
  assign m_data  = {data_two, data_one, status_byte};
  assign m_last  = last;

endmodule

// ----- rtl/scaled_midi_controller_mapper.sv -----
// path from an accepted sample to its first message on the master side
// (input register, multiply, 14 divider cells of one quotient bit each, output register)
// throughput: one sample per cycle while m_tready is high; the output register sends one
// message per cycle, so a sample that makes a controller pair stalls the chain for its second message
// reset: synchronous, clears all pipeline valid bits and loads the register defaults
module scaled_midi_controller_mapper import smcm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,  // sample_value
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,  // status_byte, data_one, data_two
  output logic                m_tlast   // last_of_run
);

  cfg_t                cfg;
  logic [SAMPLE_W:0]   in_span;
  logic [SAMPLE_W-1:0] divisor;
  logic                chain_valid [DIV_CELLS+1];
  logic                chain_ready [DIV_CELLS+1];
  div_t                chain_data  [DIV_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_min        <= 16'sd0;
      cfg.in_max        <= 16'sd127;
      cfg.out_min       <= 14'd0;
      cfg.out_max       <= 14'd127;
      cfg.channel       <= 5'd1;
      cfg.message_kind  <= KIND_CC;
      cfg.cc_number     <= 7'd1;
      cfg.cc_lsb_number <= 7'd0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        REG_IN_MIN:        cfg.in_min        <= $signed(cfg_data[SAMPLE_W-1:0]);
        REG_IN_MAX:        cfg.in_max        <= $signed(cfg_data[SAMPLE_W-1:0]);
        REG_OUT_MIN:       cfg.out_min       <= cfg_data[VALUE_W-1:0];
        REG_OUT_MAX:       cfg.out_max       <= cfg_data[VALUE_W-1:0];
        REG_CHANNEL:       cfg.channel       <= cfg_data[4:0];
        REG_MESSAGE_KIND:  cfg.message_kind  <= kind_t'(cfg_data[0]);
        REG_CC_NUMBER:     cfg.cc_number     <= cfg_data[6:0];
        REG_CC_LSB_NUMBER: cfg.cc_lsb_number <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign in_span = {cfg.in_max[SAMPLE_W-1], cfg.in_max} - {cfg.in_min[SAMPLE_W-1], cfg.in_min};
  assign divisor = in_span[SAMPLE_W-1:0];

  smcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sample    (s_tdata),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    smcm_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .divisor   (divisor),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  smcm_out u_out (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (chain_valid[DIV_CELLS]),
    .in_ready (chain_ready[DIV_CELLS]),
    .quotient (chain_data[DIV_CELLS].q),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_data   (m_tdata),
    .m_last   (m_tlast)
  );

endmodule

// ----- rtl/smcm_checker.sv -----
module smcm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // the second message of a pair follows at once
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("second message of pair missing");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tdata[7:0] == $past(m_tdata[7:0]))
    else $error("status byte differs within pair");

endmodule

bind scaled_midi_controller_mapper smcm_checker u_smcm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
